// ----- hw/rtl/id3u8_pkg.sv -----
`timescale 1ns / 1ps

package id3u8_pkg;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Most output bytes that one input byte can cause.
    localparam int MAX_OUT = 3;
    localparam int IDX_W   = $clog2(MAX_OUT);

    // Encoding byte values at the head of a frame; any other value is UTF-16.
    localparam logic [7:0]  ENC_LATIN1     = 8'd0;
    localparam logic [7:0]  ENC_UTF16_MARK = 8'd1;
    localparam logic [7:0]  ENC_UTF8       = 8'd3;

    localparam logic [7:0]  BOM_FF    = 8'hFF;
    localparam logic [7:0]  BOM_FE    = 8'hFE;
    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  CONT      = 8'h80;
    localparam logic [5:0]  CONT_MASK = 6'h3F;
    localparam logic [15:0] TWO_LIMIT = 16'h0800;
    localparam logic [15:0] ONE_LIMIT = 16'h0080;

    // One unit of work: the output bytes caused by one input byte.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [IDX_W-1:0]        cnt;    // number of results, 1 to MAX_OUT
        logic                    valid;  // 0 only for an end marker
        logic                    done;   // last results of the frame
    } job_t;

endpackage

// ----- hw/rtl/id3_text_frame_to_utf8_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_*       in         tdata[7:0] payload_byte, tlast frame_end
// m_*       out        tdata[7:0] text_byte, tuser[0] byte_valid, tuser[1] run_last,
//                      tlast text_done
//
// An input byte is taken whenever the job queue has room; it leaves
// zero to three output bytes, and the output side emits one byte per cycle while
// m_tready is high. The front part converts each byte in its accept cycle;
// its results pass through the queue and then the output register. A stall
// on m_tready fills the four-entry queue, then s_tready drops. Reset clears
// the decoder state, the queue and the output register.

module id3_text_frame_to_utf8_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_byte
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] run_last
    output logic        m_tlast
);

    id3u8_pkg::job_t push_job;
    id3u8_pkg::job_t head_job;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    id3u8_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (s_tdata),
        .frame_end    (s_tlast),
        .push         (push),
        .job          (push_job)
    );

    id3u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    id3u8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/id3u8_front.sv -----
`timescale 1ns / 1ps

module id3u8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        payload_byte,
    input  logic              frame_end,
    output logic              push,
    output id3u8_pkg::job_t   job
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_TEXT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CL_LATIN,
        CL_U16_MARK,
        CL_U16,
        CL_UTF8
    } coding_t;

    phase_t      phase_reg, phase_next;
    coding_t     coding_reg, coding_next;
    logic        little_reg, little_next;
    logic [7:0]  held_reg, held_next;
    logic        holding_reg, holding_next;
    logic        first_reg, first_next;

    logic [15:0] unit;
    logic        is_mark;

    always_comb
    begin
        unit    = little_reg ? {payload_byte, held_reg} : {held_reg, payload_byte};
        is_mark = (coding_reg == CL_U16_MARK) && first_reg &&
                  (((held_reg == id3u8_pkg::BOM_FF) && (payload_byte == id3u8_pkg::BOM_FE)) ||
                   ((held_reg == id3u8_pkg::BOM_FE) && (payload_byte == id3u8_pkg::BOM_FF)));
    end

    always_comb
    begin
        phase_next   = phase_reg;
        coding_next  = coding_reg;
        little_next  = little_reg;
        held_next    = held_reg;
        holding_next = holding_reg;
        first_next   = first_reg;
        job          = '0;
        job.valid    = 1'b1;
        push         = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    case (payload_byte)
                        id3u8_pkg::ENC_LATIN1:     coding_next = CL_LATIN;
                        id3u8_pkg::ENC_UTF16_MARK: coding_next = CL_U16_MARK;
                        id3u8_pkg::ENC_UTF8:       coding_next = CL_UTF8;
                        default:                   coding_next = CL_U16;
                    endcase
                    phase_next   = PH_TEXT;
                    little_next  = 1'b0;
                    holding_next = 1'b0;
                    first_next   = 1'b1;
                end
                PH_TEXT:
                begin
                    case (coding_reg)
                        CL_UTF8:
                        begin
                            job.bytes[0] = payload_byte;
                            job.cnt      = 2'd1;
                        end
                        CL_LATIN:
                        begin
                            if (payload_byte == 8'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (!payload_byte[7])
                            begin
                                job.bytes[0] = payload_byte;
                                job.cnt      = 2'd1;
                            end
                            else
                            begin
                                job.bytes[0] = id3u8_pkg::LEAD2 | {6'd0, payload_byte[7:6]};
                                job.bytes[1] = id3u8_pkg::CONT
                                               | {2'd0, payload_byte[5:0] & id3u8_pkg::CONT_MASK};
                                job.cnt      = 2'd2;
                            end
                        end
                        default:
                        begin
                            if (!holding_reg)
                            begin
                                held_next    = payload_byte;
                                holding_next = 1'b1;
                            end
                            else
                            begin
                                holding_next = 1'b0;
                                first_next   = 1'b0;
                                if (is_mark)
                                begin
                                    little_next = (payload_byte == id3u8_pkg::BOM_FE);
                                end
                                else if (unit == 16'd0)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else if (unit < id3u8_pkg::ONE_LIMIT)
                                begin
                                    job.bytes[0] = unit[7:0];
                                    job.cnt      = 2'd1;
                                end
                                else if (unit < id3u8_pkg::TWO_LIMIT)
                                begin
                                    job.bytes[0] = id3u8_pkg::LEAD2 | {3'd0, unit[10:6]};
                                    job.bytes[1] = id3u8_pkg::CONT | {2'd0, unit[5:0]};
                                    job.cnt      = 2'd2;
                                end
                                else
                                begin
                                    job.bytes[0] = id3u8_pkg::LEAD3 | {4'd0, unit[15:12]};
                                    job.bytes[1] = id3u8_pkg::CONT | {2'd0, unit[11:6]};
                                    job.bytes[2] = id3u8_pkg::CONT | {2'd0, unit[5:0]};
                                    job.cnt      = 2'd3;
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    // Text already ended: bytes up to the frame end are dropped.
                end
            endcase

            if (frame_end)
            begin
                if (job.cnt == 2'd0)
                begin
                    job.cnt   = 2'd1;
                    job.valid = 1'b0;
                end
                job.done     = 1'b1;
                phase_next   = PH_WAIT;
                little_next  = 1'b0;
                holding_next = 1'b0;
                first_next   = 1'b1;
            end

            push = (job.cnt != 2'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            coding_reg  <= CL_LATIN;
            little_reg  <= 1'b0;
            held_reg    <= 8'd0;
            holding_reg <= 1'b0;
            first_reg   <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            coding_reg  <= coding_next;
            little_reg  <= little_next;
            held_reg    <= held_next;
            holding_reg <= holding_next;
            first_reg   <= first_next;
        end
    end

endmodule

// ----- hw/rtl/id3u8_queue.sv -----
`timescale 1ns / 1ps

module id3u8_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  id3u8_pkg::job_t   push_job,
    input  logic              pop,
    output id3u8_pkg::job_t   head_job,
    output logic              full,
    output logic              empty
);

    id3u8_pkg::job_t                   mem_reg [id3u8_pkg::QDEPTH];
    logic [id3u8_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [id3u8_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [id3u8_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign full     = (count_reg == id3u8_pkg::QCNT_W'(id3u8_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/id3u8_back.sv -----
`timescale 1ns / 1ps

module id3u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  id3u8_pkg::job_t   head_job,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic [id3u8_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [7:0]                  data_reg, data_next;
    logic [1:0]                  user_reg, user_next;
    logic                        last_reg, last_next;

    logic load;
    logic final_byte;

    // The output register takes a new byte whenever it is empty or being drained.
    assign load       = !empty && (!valid_reg || m_tready);
    assign final_byte = (idx_reg == head_job.cnt - 1'b1);
    assign pop        = load && final_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = head_job.valid ? head_job.bytes[idx_reg] : 8'd0;
            user_next  = {final_byte, head_job.valid};
            last_next  = final_byte && head_job.done;
            idx_next   = final_byte ? '0 : idx_reg + 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            data_reg  <= 8'd0;
            user_reg  <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            data_reg  <= data_next;
            user_reg  <= user_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/id3u8_checker.sv -----
`timescale 1ns / 1ps

module id3u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled output transaction keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    // An end-only marker carries a zero byte and closes its input byte's run.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 8'd0) && m_tuser[1] && m_tlast)
        else $error("malformed end marker");

    // The frame's last result is also the last result of its input byte.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("frame end without run end");

    // Nothing is offered on the first edge after reset is released.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind id3_text_frame_to_utf8_top id3u8_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
